// ===== hw/rtl/cwa_pkg.sv =====
// cwa_pkg: shared types and constants for the centred window average block.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package cwa_pkg;

   localparam int SAMPLE_W   = 32;   // sample and average width
   localparam int SUM_W      = 39;   // running sum width
   localparam int RADIUS_W   = 6;    // half width k
   localparam int DIVISOR_W  = 7;    // window size 2k+1
   localparam int HIST_DEPTH = 128;  // sample ring
   localparam int HIST_AW    = 7;
   localparam int SEEN_MAX   = 127;  // sample count saturates here
   localparam int CMD_DEPTH  = 4;    // front to back queue
   localparam int CMD_AW     = 2;
   localparam int STEP_W     = 6;    // divider step counter

   localparam logic signed [SAMPLE_W-1:0] NO_AVERAGE = '1;  // -1

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       end_of_array;
   } cwa_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] average;
      logic                       full_window;
      logic                       last_result;
   } cwa_rsp_type;

   // One classified item, as handed from front to back
   typedef struct packed {
      logic                       first;     // item yields a result of its own
      logic                       full;      // that result is a full window
      logic                       last;      // end of array
      logic [RADIUS_W-1:0]        trail;     // trailing -1 results
      logic [DIVISOR_W-1:0]       divisor;
      logic signed [SUM_W-1:0]    dividend;
   } cwa_cmd_type;

   typedef struct packed {
      logic                       start;
      logic [DIVISOR_W-1:0]       divisor;
      logic signed [SUM_W-1:0]    dividend;
   } cwa_div_req_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_PUT,
      BACK_TRAIL
   } cwa_back_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cwa_front.sv =====
// cwa_front: accepts samples, keeps the sample ring and running sum, and
// classifies each sample into a command for the back end. Uses cwa_pkg.
`default_nettype none

module cwa_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [5:0]            radius,
   input  logic                  req_push,
   output logic                  req_full,
   input  cwa_pkg::cwa_req_type  req_data,
   output logic                  cmd_push,
   output cwa_pkg::cwa_cmd_type  cmd_data,
   input  logic                  cmd_full
);
   import cwa_pkg::*;

   logic                       accept;
   logic signed [SUM_W-1:0]    sum_ff, sum_in, x_ext, sum_plus;
   logic [HIST_AW-1:0]         seen_ff, seen_in, wp_ff, wp_in, rd_addr, twice_k;
   logic [HIST_AW:0]           seen_next;
   logic                       busy_ff, busy_in, sub_ff, sub_in;
   logic                       bypass_ff;
   logic signed [SAMPLE_W-1:0] x_ff, old_ff, old_val;
   logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
   logic                       first, full;
   logic [RADIUS_W-1:0]        trail;

   // Classification of the incoming sample
   assign twice_k   = {radius, 1'b0};
   assign req_full  = busy_ff || cmd_full;
   assign accept    = req_push && !req_full;
   assign x_ext     = SUM_W'(req_data.sample);
   assign sum_plus  = sum_ff + x_ext;
   assign first     = seen_ff >= {1'b0, radius};
   assign full      = seen_ff >= twice_k;
   assign seen_next = {1'b0, seen_ff} + 1'b1;
   assign rd_addr   = wp_ff - twice_k;

   always_comb begin
      if (!req_data.end_of_array) begin
         trail = '0;
      end else if (seen_next < {2'b00, radius}) begin
         trail = seen_next[RADIUS_W-1:0];
      end else begin
         trail = radius;
      end
   end

   // Command towards the back end; nothing is queued for a silent sample
   assign cmd_push          = accept && (first || req_data.end_of_array);
   assign cmd_data.first    = first;
   assign cmd_data.full     = full;
   assign cmd_data.last     = req_data.end_of_array;
   assign cmd_data.trail    = trail;
   assign cmd_data.divisor  = {radius, 1'b1};
   assign cmd_data.dividend = sum_plus;

   // With k of zero the sample leaving the window is the one just written
   assign old_val = bypass_ff ? x_ff : old_ff;

   // Next state: add on transfer, take the oldest sample off in the following cycle
   always_comb begin
      sum_in  = sum_ff;
      seen_in = seen_ff;
      wp_in   = wp_ff;
      busy_in = 1'b0;
      sub_in  = 1'b0;
      if (accept) begin
         busy_in = 1'b1;
         wp_in   = wp_ff + 1'b1;
         seen_in = (seen_ff == HIST_AW'(SEEN_MAX)) ? seen_ff : seen_next[HIST_AW-1:0];
         sub_in  = full && !req_data.end_of_array;
         sum_in  = sum_plus;
         if (req_data.end_of_array) begin
            sum_in  = '0;
            seen_in = '0;
         end
      end else if (busy_ff && sub_ff) begin
         sum_in = sum_ff - SUM_W'(old_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         seen_ff <= '0;
         wp_ff   <= '0;
         busy_ff <= 1'b0;
         sub_ff  <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         seen_ff <= seen_in;
         wp_ff   <= wp_in;
         busy_ff <= busy_in;
         sub_ff  <= sub_in;
      end
   end

   // Sample ring: write at the write pointer, registered read 2k behind it
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_mem[wp_ff] <= req_data.sample;
         old_ff          <= hist_mem[rd_addr];
         x_ff            <= req_data.sample;
         bypass_ff       <= (radius == '0);
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cwa_cmd_queue.sv =====
// cwa_cmd_queue: short command queue between front and back end.
// Uses cwa_pkg for the command type and depth.
`default_nettype none

module cwa_cmd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cwa_pkg::cwa_cmd_type  data_in,
   output logic                  full,
   input  logic                  pop,
   output cwa_pkg::cwa_cmd_type  data_out,
   output logic                  empty
);
   import cwa_pkg::*;

   cwa_cmd_type       entry_mem [CMD_DEPTH];
   logic [CMD_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CMD_AW:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == (CMD_AW+1)'(CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = entry_mem[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_mem[wr_ptr_ff] <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cwa_divider.sv =====
// cwa_divider: radix-2 restoring divider, signed 39-bit sum by a 7-bit
// window size, quotient truncated toward zero. Uses cwa_pkg.
`default_nettype none

module cwa_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  cwa_pkg::cwa_div_req_type          div_req,
   output logic                              done,
   output logic signed [cwa_pkg::SAMPLE_W-1:0] quotient
);
   import cwa_pkg::*;

   logic                  busy_ff, busy_in, done_ff, done_in;
   logic                  neg_ff, neg_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in, div_ff, div_in;
   logic [SUM_W-1:0]      work_ff, work_in, magnitude;
   logic [DIVISOR_W:0]    trial, trial_diff;
   logic                  ge;

   // Work on the magnitude, fix the sign at the end
   assign magnitude  = div_req.dividend[SUM_W-1] ? SUM_W'(-div_req.dividend)
                                                 : div_req.dividend;
   assign trial      = {rem_ff, work_ff[SUM_W-1]};
   assign ge         = trial >= {1'b0, div_ff};
   assign trial_diff = trial - {1'b0, div_ff};

   // One quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      work_in = work_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.dividend[SUM_W-1];
         step_in = STEP_W'(SUM_W - 1);
         rem_in  = '0;
         div_in  = div_req.divisor;
         work_in = magnitude;
      end else if (busy_ff) begin
         rem_in  = ge ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         work_in = {work_ff[SUM_W-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      work_ff <= work_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -work_ff[SAMPLE_W-1:0] : work_ff[SAMPLE_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/cwa_back.sv =====
// cwa_back: carries out queued commands, runs the divider and drives the
// result register. Uses cwa_pkg.
`default_nettype none

module cwa_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_empty,
   input  cwa_pkg::cwa_cmd_type              cmd_data,
   output logic                              cmd_pop,
   output cwa_pkg::cwa_div_req_type          div_req,
   input  logic                              div_done,
   input  logic signed [cwa_pkg::SAMPLE_W-1:0] quotient,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output cwa_pkg::cwa_rsp_type              rsp_data
);
   import cwa_pkg::*;

   cwa_back_state_type         state_ff, state_in;
   logic [RADIUS_W-1:0]        trail_ff, trail_in;
   logic                       last_ff, last_in;
   logic signed [SAMPLE_W-1:0] avg_ff, avg_in;
   logic                       fullw_ff, fullw_in;
   logic                       out_valid_ff, out_valid_in, out_load, out_free;
   cwa_rsp_type                out_ff, out_in;

   assign out_free = !out_valid_ff || rsp_pop;

   // Sequencer: one command may give a result and a run of trailing results
   always_comb begin
      state_in         = state_ff;
      trail_in         = trail_ff;
      last_in          = last_ff;
      avg_in           = avg_ff;
      fullw_in         = fullw_ff;
      cmd_pop          = 1'b0;
      div_req.start    = 1'b0;
      div_req.divisor  = cmd_data.divisor;
      div_req.dividend = cmd_data.dividend;
      out_load         = 1'b0;
      out_in           = out_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               trail_in = cmd_data.trail;
               last_in  = cmd_data.last;
               if (cmd_data.first && cmd_data.full) begin
                  div_req.start = 1'b1;
                  state_in      = BACK_DIVIDE;
               end else if (cmd_data.first) begin
                  avg_in   = NO_AVERAGE;
                  fullw_in = 1'b0;
                  state_in = BACK_PUT;
               end else begin
                  state_in = BACK_TRAIL;
               end
            end
         end
         BACK_DIVIDE: begin
            if (div_done) begin
               avg_in   = quotient;
               fullw_in = 1'b1;
               state_in = BACK_PUT;
            end
         end
         BACK_PUT: begin
            if (out_free) begin
               out_load           = 1'b1;
               out_in.average     = avg_ff;
               out_in.full_window = fullw_ff;
               out_in.last_result = last_ff && (trail_ff == '0);
               state_in           = (trail_ff != '0) ? BACK_TRAIL : BACK_IDLE;
            end
         end
         BACK_TRAIL: begin
            if (out_free) begin
               out_load           = 1'b1;
               out_in.average     = NO_AVERAGE;
               out_in.full_window = 1'b0;
               out_in.last_result = last_ff && (trail_ff == RADIUS_W'(1));
               trail_in           = trail_ff - 1'b1;
               if (trail_ff == RADIUS_W'(1)) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // Result register
   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      trail_ff <= trail_in;
      last_ff  <= last_in;
      avg_ff   <= avg_in;
      fullw_ff <= fullw_in;
      out_ff   <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/centered_window_average.sv =====
// centered_window_average: top level of the centred window average block.
// Instantiates cwa_front, cwa_cmd_queue, cwa_back and cwa_divider; uses cwa_pkg.
//
// Usage:
//  - Samples enter through a queue-style port: a transfer happens when req_push
//    is high and req_full is low. end_of_array marks the final sample.
//  - Results leave through a queue-style port: the oldest result sits on
//    rsp_data while rsp_empty is low and is taken when rsp_pop is high.
//  - csr_wr_en writes the half width k from csr_wr_data; only while idle.
//    Values above MAX_RADIUS are used as MAX_RADIUS.
//  - The front end takes no sample while it updates the running sum after a
//    transfer, and queues up to 4 commands. A full-window result goes through
//    the radix-2 divider, and the back end takes no new command until the
//    divider is done; a -1 result skips the divider. The divider loop sets the pace.
//  - Results appear k samples behind the input; the end of an array flushes
//    the trailing -1 results, one per cycle while the receiver keeps taking them.
//  - Reset clears the radius, running sum, counters, queue and result
//    register. The sample ring is not cleared.
//  - When the receiver stalls, the result register holds, the back end waits,
//    the queue fills and req_full rises; nothing is dropped.
`default_nettype none

module centered_window_average #(
   parameter int MAX_RADIUS = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [5:0]           csr_wr_data,
   input  logic                 req_push,
   output logic                 req_full,
   input  cwa_pkg::cwa_req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output cwa_pkg::cwa_rsp_type rsp_data
);
   import cwa_pkg::*;

   logic [RADIUS_W-1:0]        radius_ff, radius_in, radius_eff;
   logic                       cmd_push, cmd_full, cmd_pop, cmd_empty;
   cwa_cmd_type                cmd_wr_data, cmd_rd_data;
   cwa_div_req_type            div_req;
   logic                       div_done;
   logic signed [SAMPLE_W-1:0] quotient;

   // Radius register
   assign radius_in  = csr_wr_en ? csr_wr_data : radius_ff;
   assign radius_eff = (radius_ff > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS)
                                                           : radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else begin
         radius_ff <= radius_in;
      end
   end

   cwa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .radius   (radius_eff),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wr_data),
      .cmd_full (cmd_full)
   );

   cwa_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .data_in  (cmd_wr_data),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .data_out (cmd_rd_data),
      .empty    (cmd_empty)
   );

   cwa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (quotient)
   );

   cwa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rd_data),
      .cmd_pop   (cmd_pop),
      .div_req   (div_req),
      .div_done  (div_done),
      .quotient  (quotient),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // Front only queues a command when there is room for it
   assert property (@(posedge clock) disable iff (reset) cmd_push |-> !cmd_full)
      else $error("command queue overrun");

   // Back only takes a command that is there
   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> !cmd_empty)
      else $error("command queue underrun");

   // A sample transfer is followed by the update cycle for the running sum
   assert property (@(posedge clock) disable iff (reset)
                    (req_push && !req_full) |=> req_full)
      else $error("sample taken during sum update");

   // No result is offered straight after reset
   assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result offered after reset");
`endif

endmodule

`default_nettype wire

// ===== tb/window_average_checker.sv =====
// window_average_checker: watches the transfers of centered_window_average and
// predicts the averages it should produce. Depends on cwa_pkg only.
// Counts mismatches and hands the count and the number of waiting results up.
module window_average_checker #(
   parameter int MAX_RADIUS = 63
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [cwa_pkg::RADIUS_W-1:0]  csr_wr_data,
   input  logic                          req_push,
   input  logic                          req_full,
   input  cwa_pkg::cwa_req_type          req_data,
   input  logic                          rsp_empty,
   input  logic                          rsp_pop,
   input  cwa_pkg::cwa_rsp_type          rsp_data,
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import cwa_pkg::*;

   // Predictor state, a private copy of the block's
   logic [RADIUS_W-1:0]        radius_q;
   logic signed [SAMPLE_W-1:0] history [HIST_DEPTH];
   logic [SUM_W-1:0]           sum_q;
   logic [HIST_AW-1:0]         seen_q;
   logic [HIST_AW-1:0]         wptr_q;

   cwa_rsp_type expected_averages [$];
   int          mismatches = 0;
   cwa_rsp_type want;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic cwa_rsp_type make_result(logic signed [SAMPLE_W-1:0] avg, logic full);
      return {avg, full, 1'b0};
   endfunction

   // Work out every average caused by one accepted sample
   task automatic predict_averages(input cwa_req_type item);
      int                         k;
      int                         i;
      int                         t;
      bit                         have_first;
      cwa_rsp_type                first_r;
      cwa_rsp_type                trail_r;
      longint                     sum_signed;
      longint                     quotient;
      logic signed [SAMPLE_W-1:0] oldest;
      k = (radius_q > MAX_RADIUS) ? MAX_RADIUS : radius_q;
      i = seen_q;
      have_first = 0;
      history[wptr_q] = item.sample;
      sum_q = sum_q + {{(SUM_W-SAMPLE_W){item.sample[SAMPLE_W-1]}}, item.sample};
      if (i >= k) begin
         have_first = 1;
         if (i >= 2 * k) begin
            // full window: divide the whole 39-bit sum, truncating toward zero
            sum_signed = $signed(sum_q);
            quotient   = sum_signed / longint'(2 * k + 1);
            first_r    = make_result(quotient[SAMPLE_W-1:0], 1'b1);
            oldest     = history[wptr_q - HIST_AW'(2 * k)];
            sum_q      = sum_q - {{(SUM_W-SAMPLE_W){oldest[SAMPLE_W-1]}}, oldest};
         end else begin
            first_r = make_result(NO_AVERAGE, 1'b0);
         end
      end
      wptr_q = wptr_q + 1'b1;
      if (seen_q < SEEN_MAX)
         seen_q = seen_q + 1'b1;
      t = 0;
      if (item.end_of_array)
         t = (i + 1 < k) ? i + 1 : k;
      if (have_first) begin
         first_r.last_result = item.end_of_array && (t == 0);
         expected_averages.push_back(first_r);
      end
      // trailing -1 results flushed by the end of the array
      for (int j = 0; j < t; j++) begin
         trail_r = make_result(NO_AVERAGE, 1'b0);
         trail_r.last_result = (j == t - 1);
         expected_averages.push_back(trail_r);
      end
      if (item.end_of_array) begin
         sum_q  = '0;
         seen_q = '0;
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s", $realtime, what);
   endtask

   // Compare result transfers, then track configuration and sample transfers
   always @(posedge clock) begin
      if (reset) begin
         radius_q = '0;
         sum_q    = '0;
         seen_q   = '0;
         wptr_q   = '0;
         expected_averages.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_averages.size() == 0) begin
               report_mismatch($sformatf("result with none expected: average %0d full %0b last %0b",
                                         rsp_data.average, rsp_data.full_window,
                                         rsp_data.last_result));
            end else begin
               want = expected_averages.pop_front();
               if (rsp_data.average !== want.average ||
                   rsp_data.full_window !== want.full_window ||
                   rsp_data.last_result !== want.last_result)
                  report_mismatch($sformatf(
                     "mismatch: expected average %0d full %0b last %0b, got %0d %0b %0b",
                     want.average, want.full_window, want.last_result,
                     rsp_data.average, rsp_data.full_window, rsp_data.last_result));
            end
         end
         if (csr_wr_en)
            radius_q = csr_wr_data;
         if (req_push && !req_full)
            predict_averages(req_data);
      end
      fail_count <= mismatches;
      pending    <= expected_averages.size();
   end

endmodule

// ===== tb/testbench.sv =====
// testbench: stimulus and verdict for centered_window_average.
// Depends on cwa_pkg, the block itself and window_average_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cwa_pkg::*;

   localparam int IDLE_LIMIT    = 4000;  // cycles without any transfer
   localparam int SETTLE_CYCLES = 100;   // block left to go quiet before a write
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int RANDOM_ITEMS  = 100;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [RADIUS_W-1:0] csr_wr_data = '0;
   logic                req_push = 1'b0;
   logic                req_full;
   cwa_req_type         req_data = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   cwa_rsp_type         rsp_data;

   int fail_count;
   int pending;
   int idle_cycles = 0;
   int hold_left = 0;
   bit hold_req = 0;
   bit tx_idling = 1;
   bit rx_idling = 1;

   centered_window_average uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

   window_average_checker averages_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Receiver: random idling, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !(rx_idling && $urandom_range(99) < 6);
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long
   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("testbench failed");
      $finish;
   end

   // Offer one sample and hold it until the transfer
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic eoa);
      while (tx_idling && $urandom_range(99) < 6) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= {value, eoa};
      @(posedge clock);
      while (req_full !== 1'b0)
         @(posedge clock);
   endtask

   // Stop offering, wait for every result, then let the block go quiet
   task automatic finish_phase();
      req_push <= 1'b0;
      // wait so the count includes the last transfer
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_radius(input int value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= RADIUS_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Extremes and small values often, so sums go beyond 32 bits and cancel
   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3:    return $signed($urandom_range(0, 20)) - 10;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int phase;
      int sent;
      int k;
      int len;
      int arrays;
      bit terminate;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Radius of zero: every sample is its own average
      set_radius(0);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(0, 1'b0);
      send_sample(-1, 1'b1);
      finish_phase();

      // Radius one with sums beyond 32 bits
      set_radius(1);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(32'sh8000_0000, 1'b1);
      finish_phase();

      // Arrays shorter than the radius, including a single sample
      set_radius(3);
      send_sample(5, 1'b0);
      send_sample(-7, 1'b1);
      send_sample(12345, 1'b1);
      finish_phase();

      // Largest radius on a short array
      set_radius(63);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(1, 1'b1);
      finish_phase();

      // Radius changed in the middle of an array
      set_radius(2);
      send_sample(100, 1'b0);
      send_sample(200, 1'b0);
      send_sample(300, 1'b0);
      finish_phase();
      set_radius(1);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(-5, 1'b0);
      send_sample(9, 1'b1);
      finish_phase();

      // Receiver holds off while the sender fills the block
      set_radius(0);
      hold_req = 1;
      for (int j = 0; j < 20; j++)
         send_sample(random_sample(), j == 19);
      finish_phase();

      // Random phases: mostly small radii and well-formed arrays;
      // the longest radius runs with no idling on either side
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS || phase < 3) begin
         tx_idling = (phase != 2);
         rx_idling = (phase != 2);
         if (phase == 2)
            k = 63;
         else if (phase == 5 || phase == 8)
            k = $urandom_range(0, 63);
         else if (phase == 3)
            k = 1;
         else
            k = $urandom_range(0, 6);
         set_radius(k);
         arrays = (phase == 2) ? 1 : $urandom_range(1, 3);
         for (int a = 0; a < arrays; a++) begin
            if (phase == 2)
               len = 130;
            else if (phase == 3)
               len = 40;
            else if (phase == 5 || phase == 8)
               len = $urandom_range(1, k + 2);
            else
               len = $urandom_range(1, 3 * k + 4);
            // now and then leave the last array open
            terminate = !(a == arrays - 1 && $urandom_range(0, 4) == 0);
            for (int j = 0; j < len; j++)
               send_sample(random_sample(), terminate && j == len - 1);
            sent += len;
         end
         finish_phase();
         phase++;
      end

      // Sender and receiver idling back on for the tail
      tx_idling = 1;
      rx_idling = 1;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
